// ===== rtl/sg2d_pkg.sv =====
// ----------------------------------------------------------------------------
// sg2d_pkg
// Shared types, constants and the weight table for the five-point
// Savitzky-Golay second-derivative unit.
// ----------------------------------------------------------------------------
package sg2d_pkg;

    localparam int SG2D_TAPS       = 5;
    localparam int SG2D_MAX_POINTS = 4096;
    localparam int SG2D_CNT_W      = $clog2(SG2D_MAX_POINTS + 1);
    localparam int SG2D_POS_W      = 12;
    localparam int SG2D_IDX_W      = 3;
    localparam int SG2D_SAMPLE_W   = 32;
    localparam int SG2D_SCALE_W    = 32;
    localparam int SG2D_RESULT_W   = 64;
    localparam int SG2D_WEIGHT_W   = 6;

    // Row that holds the centred kernel
    localparam logic [SG2D_IDX_W-1:0] SG2D_ROW_CENTER = 3'd2;
    localparam logic [SG2D_IDX_W-1:0] SG2D_ROW_LAST   = 3'd4;
    localparam logic [SG2D_IDX_W-1:0] SG2D_TAP_LAST   = 3'd4;

    // Weights times 14; row = endpoint-matrix column, oldest sample first
    localparam logic signed [SG2D_WEIGHT_W-1:0] SG2D_WEIGHTS [SG2D_TAPS][SG2D_TAPS] = '{
        '{ 6'sd18, -6'sd30, -6'sd4,  6'sd26, -6'sd10},
        '{ 6'sd11, -6'sd16, -6'sd4,  6'sd12, -6'sd3 },
        '{ 6'sd4,  -6'sd2,  -6'sd4, -6'sd2,   6'sd4 },
        '{-6'sd3,   6'sd12, -6'sd4, -6'sd16,  6'sd11},
        '{-6'sd10,  6'sd26, -6'sd4, -6'sd30,  6'sd18}
    };

    typedef enum logic [2:0] {
        MAC_IDLE,
        MAC_TAP_FIRST,
        MAC_TAP_ACC,
        MAC_ABS,
        MAC_LO,
        MAC_HI
    } sg2d_mac_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAP,
        S_ABS,
        S_LO,
        S_HI,
        S_ERR
    } sg2d_state_t;

    typedef struct packed {
        sg2d_mac_op_t            op;
        logic [SG2D_IDX_W-1:0]   tap;
        logic                    emit;
        logic                    error;
        logic                    last_res;
        logic [SG2D_POS_W-1:0]   pos;
        logic                    clear;
    } sg2d_ctrl_t;

    function automatic logic signed [SG2D_WEIGHT_W-1:0] sg2d_weight(
        input logic [SG2D_IDX_W-1:0] row,
        input logic [SG2D_IDX_W-1:0] tap
    );
        logic signed [SG2D_WEIGHT_W-1:0] w;
        w = '0;
        if (row <= SG2D_ROW_LAST && tap <= SG2D_TAP_LAST)
        begin
            w = SG2D_WEIGHTS[row][tap];
        end
        return w;
    endfunction

endpackage

// ===== rtl/sg2d_mac.sv =====
// ----------------------------------------------------------------------------
// sg2d_mac
// Shared multiply-accumulate unit: five weighted taps, magnitude, then the
// scale product in two halves with round-to-nearest.
// ----------------------------------------------------------------------------
module sg2d_mac
    import sg2d_pkg::*;
(
    input  logic                              clk,
    input  sg2d_mac_op_t                      op,
    input  logic        [SG2D_IDX_W-1:0]      row,
    input  logic        [SG2D_IDX_W-1:0]      tap,
    input  logic signed [SG2D_SAMPLE_W-1:0]   tap_sample,
    input  logic        [SG2D_SCALE_W-1:0]    scale,
    output logic signed [SG2D_RESULT_W-1:0]   deriv
);

    localparam int OP_W   = 33;
    localparam int PROD_W = 2 * OP_W;
    localparam int ACC_W  = 40;
    localparam int MAG_W  = 39;
    localparam int LO_W   = 16;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int RND_W  = 49;
    localparam int PART_W = RND_W - LO_W;
    localparam int Q_W    = 56;

    logic signed [OP_W-1:0]   mul_a;
    logic signed [OP_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;

    logic signed [ACC_W-1:0]  acc_reg;
    logic        [MAG_W-1:0]  mag_reg;
    logic                     neg_reg;
    logic        [PART_W-1:0] lo_reg;

    logic        [RND_W-1:0]  lo_sum;
    logic        [Q_W-1:0]    q_sum;
    logic        [SG2D_RESULT_W-1:0] q_ext;

    // Operand select for the one multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (op)
            MAC_TAP_FIRST, MAC_TAP_ACC:
            begin
                mul_a = OP_W'(tap_sample);
                mul_b = OP_W'(sg2d_weight(row, tap));
            end
            MAC_LO:
            begin
                mul_a = {{(OP_W-LO_W){1'b0}}, mag_reg[LO_W-1:0]};
                mul_b = {1'b0, scale};
            end
            MAC_HI:
            begin
                mul_a = {{(OP_W-HI_W){1'b0}}, mag_reg[MAG_W-1:LO_W]};
                mul_b = {1'b0, scale};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Low partial product plus rounding bias; ties go toward +infinity
    assign lo_sum = prod[RND_W-1:0] + (neg_reg ? RND_W'(16'h7FFF) : RND_W'(16'h8000));
    assign q_sum  = prod[Q_W-1:0] + Q_W'(lo_reg);
    assign q_ext  = SG2D_RESULT_W'(q_sum);
    assign deriv  = neg_reg ? -$signed(q_ext) : $signed(q_ext);

    always_ff @(posedge clk)
    begin
        unique case (op)
            MAC_TAP_FIRST: acc_reg <= prod[ACC_W-1:0];
            MAC_TAP_ACC:   acc_reg <= acc_reg + prod[ACC_W-1:0];
            MAC_ABS:
            begin
                neg_reg <= acc_reg[ACC_W-1];
                mag_reg <= acc_reg[ACC_W-1] ? MAG_W'(-acc_reg) : MAG_W'(acc_reg);
            end
            MAC_LO:        lo_reg <= lo_sum[RND_W-1:LO_W];
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

endmodule

// ===== rtl/sg2d_seq.sv =====
// ----------------------------------------------------------------------------
// sg2d_seq
// Sequencer: counts samples, picks the kernel rows each item needs and steps
// the shared MAC through taps, magnitude and scaling for each result.
// ----------------------------------------------------------------------------
module sg2d_seq
    import sg2d_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    input  logic                   last_sample,
    input  logic                   out_free,
    output logic                   sample_ready,
    output logic [SG2D_IDX_W-1:0]  row,
    output sg2d_ctrl_t             ctrl
);

    sg2d_state_t             state_reg, state_next;
    logic [SG2D_CNT_W-1:0]   count_reg, count_next;
    logic [SG2D_IDX_W-1:0]   row_reg,   row_next;
    logic [SG2D_IDX_W-1:0]   tap_reg,   tap_next;
    logic                    last_reg,  last_next;
    logic [SG2D_CNT_W-1:0]   count_inc;
    logic [SG2D_CNT_W-1:0]   pos_full;

    assign count_inc = (count_reg == SG2D_CNT_W'(SG2D_MAX_POINTS)) ? count_reg
                                                                   : count_reg + 1'b1;
    // Position is count - 5 + row for every row
    assign pos_full  = count_reg - SG2D_CNT_W'(SG2D_TAPS) + SG2D_CNT_W'(row_reg);
    assign row       = row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            row_reg   <= '0;
            tap_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            row_reg   <= row_next;
            tap_reg   <= tap_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        row_next      = row_reg;
        tap_next      = tap_reg;
        last_next     = last_reg;
        sample_ready  = 1'b0;
        ctrl          = '0;
        ctrl.op       = MAC_IDLE;
        ctrl.tap      = tap_reg;
        ctrl.pos      = pos_full[SG2D_POS_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    count_next = count_inc;
                    last_next  = last_sample;
                    tap_next   = '0;
                    if (count_inc >= SG2D_CNT_W'(SG2D_TAPS))
                    begin
                        row_next   = (count_inc == SG2D_CNT_W'(SG2D_TAPS)) ? '0
                                                                            : SG2D_ROW_CENTER;
                        state_next = S_TAP;
                    end
                    else if (last_sample)
                    begin
                        state_next = S_ERR;
                    end
                end
            end
            S_TAP:
            begin
                ctrl.op  = (tap_reg == '0) ? MAC_TAP_FIRST : MAC_TAP_ACC;
                tap_next = tap_reg + 1'b1;
                if (tap_reg == SG2D_TAP_LAST)
                begin
                    state_next = S_ABS;
                end
            end
            S_ABS:
            begin
                ctrl.op    = MAC_ABS;
                state_next = S_LO;
            end
            S_LO:
            begin
                ctrl.op    = MAC_LO;
                state_next = S_HI;
            end
            S_HI:
            begin
                ctrl.op = MAC_HI;
                if (out_free)
                begin
                    ctrl.emit     = 1'b1;
                    ctrl.last_res = last_reg && (row_reg == SG2D_ROW_LAST);
                    tap_next      = '0;
                    if (row_reg < SG2D_ROW_CENTER ||
                        (last_reg && row_reg != SG2D_ROW_LAST))
                    begin
                        row_next   = row_reg + 1'b1;
                        state_next = S_TAP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                        if (last_reg)
                        begin
                            ctrl.clear = 1'b1;
                            count_next = '0;
                        end
                    end
                end
            end
            S_ERR:
            begin
                ctrl.pos = '0;
                if (out_free)
                begin
                    ctrl.emit     = 1'b1;
                    ctrl.error    = 1'b1;
                    ctrl.last_res = 1'b1;
                    ctrl.clear    = 1'b1;
                    count_next    = '0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/savgol_second_derivative_5pt_unit.sv =====
// ----------------------------------------------------------------------------
// savgol_second_derivative_5pt_unit
// Streaming five-point Savitzky-Golay cubic second derivative, fixed point.
// ----------------------------------------------------------------------------
// Samples (signed Q8.24) arrive one per transfer with last_sample on the final
// one. Each result is (sum of integer weights x window) * inv_step_sq_scale
// (unsigned Q16.16, 1/(14*dT^2)), rounded to nearest with ties toward plus
// infinity, as signed Q40.24 in 64 bits. The fifth sample yields positions 0,
// 1 and 2; each later sample yields one centred result; the last sample adds
// the two end positions, the final one flagged by last_result. A sequence of
// fewer than five samples yields one result with too_short set and value 0.
// Sequencing: each result steps the single shared multiply-accumulate unit
// (five taps, magnitude, low and high scale halves); an item with results
// holds sample_ready low until its last one is loaded, including any wait
// for result_ready, as a short-sequence item does in the error state. An
// item with no result is taken every cycle. The result register lets the
// next sample transfer while a result waits.
// ----------------------------------------------------------------------------
module savgol_second_derivative_5pt_unit
    import sg2d_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic        [SG2D_SCALE_W-1:0]    cfg_wdata,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  logic signed [SG2D_SAMPLE_W-1:0]   sample,
    input  logic                              last_sample,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic signed [SG2D_RESULT_W-1:0]   second_derivative,
    output logic        [SG2D_POS_W-1:0]      position,
    output logic                              too_short,
    output logic                              last_result
);

    logic [SG2D_SCALE_W-1:0]          scale_reg;
    logic signed [SG2D_SAMPLE_W-1:0]  window_reg [SG2D_TAPS];
    logic signed [SG2D_SAMPLE_W-1:0]  tap_sample;
    logic signed [SG2D_RESULT_W-1:0]  deriv;
    logic                             out_valid_reg;
    logic signed [SG2D_RESULT_W-1:0]  out_deriv_reg;
    logic [SG2D_POS_W-1:0]            out_pos_reg;
    logic                             out_short_reg;
    logic                             out_last_reg;
    logic                             out_free;
    logic                             sample_xfer;
    logic [SG2D_IDX_W-1:0]            row;
    sg2d_ctrl_t                       ctrl;

    assign sample_xfer = sample_valid && sample_ready;
    // Result register may be loaded when empty or being drained this cycle
    assign out_free    = !out_valid_reg || result_ready;

    // Scale register: written whenever the write enable is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SG2D_SCALE_W'(32'h0001_0000);
        end
        else if (cfg_we)
        begin
            scale_reg <= cfg_wdata;
        end
    end

    // Sample window: advance on transfer, drop everything at sequence end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SG2D_TAPS; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < SG2D_TAPS; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (sample_xfer)
        begin
            for (int i = 0; i < SG2D_TAPS - 1; i++)
            begin
                window_reg[i] <= window_reg[i+1];
            end
            window_reg[SG2D_TAPS-1] <= sample;
        end
    end

    // Tap select for the MAC, oldest sample at tap 0
    always_comb
    begin
        unique case (ctrl.tap)
            3'd0:    tap_sample = window_reg[0];
            3'd1:    tap_sample = window_reg[1];
            3'd2:    tap_sample = window_reg[2];
            3'd3:    tap_sample = window_reg[3];
            3'd4:    tap_sample = window_reg[4];
            default: tap_sample = '0;
        endcase
    end

    sg2d_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .last_sample  (last_sample),
        .out_free     (out_free),
        .sample_ready (sample_ready),
        .row          (row),
        .ctrl         (ctrl)
    );

    sg2d_mac u_mac (
        .clk        (clk),
        .op         (ctrl.op),
        .row        (row),
        .tap        (ctrl.tap),
        .tap_sample (tap_sample),
        .scale      (scale_reg),
        .deriv      (deriv)
    );

    // Result register: hold until transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            out_deriv_reg <= ctrl.error ? '0 : deriv;
            out_pos_reg   <= ctrl.pos;
            out_short_reg <= ctrl.error;
            out_last_reg  <= ctrl.last_res;
        end
    end

    assign result_valid      = out_valid_reg;
    assign second_derivative = out_deriv_reg;
    assign position          = out_pos_reg;
    assign too_short         = out_short_reg;
    assign last_result       = out_last_reg;

endmodule

// ===== rtl/sg2d_checker.sv =====
// ----------------------------------------------------------------------------
// sg2d_checker
// Port-level checks for the second-derivative unit, bound to the top level.
// ----------------------------------------------------------------------------
module sg2d_checker
    import sg2d_pkg::*;
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              sample_valid,
    input logic                              sample_ready,
    input logic                              last_sample,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic signed [SG2D_RESULT_W-1:0]   second_derivative,
    input logic        [SG2D_POS_W-1:0]      position,
    input logic                              too_short,
    input logic                              last_result
);

    // An error result is always the final one of its sequence
    a_short_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && too_short |-> last_result)
        else $error("too_short result without last_result");

    // An error result carries zero value at position zero
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && too_short |-> (second_derivative == '0 && position == '0))
        else $error("too_short result with nonzero payload");

    // A final sample always produces work, so input stalls right after it
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready && last_sample |=> !sample_ready)
        else $error("sample_ready high right after final sample");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(second_derivative) && $stable(position))
        else $error("stalled result changed");

endmodule

bind savgol_second_derivative_5pt_unit sg2d_checker u_sg2d_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .sample_valid      (sample_valid),
    .sample_ready      (sample_ready),
    .last_sample       (last_sample),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .second_derivative (second_derivative),
    .position          (position),
    .too_short         (too_short),
    .last_result       (last_result)
);
